### hw/rtl/ir_pwc_pkg.sv
// Shared types and constants of the IR pulse width capture block.
// Used by the capture engine, the result queue and the top level.
package ir_pwc_pkg;

    localparam int ENTRY_W = 7;
    localparam int LIMIT_W = 24;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_PERIOD   = 3'd0;
    localparam logic [2:0] REG_DATA_PERIOD    = 3'd1;
    localparam logic [2:0] REG_DURATION_LIMIT = 3'd2;
    localparam logic [2:0] REG_IDLE_LIMIT     = 3'd3;
    localparam logic [2:0] REG_MIN_ENTRIES    = 3'd4;

    // Capture modes.
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WAIT    = 2'd1;
    localparam logic [1:0] MODE_MEASURE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_ENTRY    = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    // Result queue depth; one item can push two results.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef struct packed {
        logic [7:0]         start_period;
        logic [7:0]         data_period;
        logic [7:0]         duration_limit;
        logic [LIMIT_W-1:0] idle_limit;
        logic [ENTRY_W-1:0] min_entries;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         duration;
        logic [ENTRY_W-1:0] entry_index;
        logic [ENTRY_W-1:0] entry_total;
        logic [1:0]         status;
        logic               last;
    } res_t;

    typedef struct packed {
        logic push0;
        logic push1;
        res_t res0;
        res_t res1;
    } step_t;

endpackage

### hw/rtl/ir_pwc_engine.sv
// Capture state machine: idle wait, prescaled sampling and phase counting.
// Depends on ir_pwc_pkg; produces up to two results per accepted item.
module ir_pwc_engine
    import ir_pwc_pkg::*;
#(
    parameter int MAX_ENTRIES = 74
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        req_type,
    input  logic        sensor_level,
    input  cfg_t        cfg,
    output step_t       step
);

    localparam logic [ENTRY_W-1:0] MAX_E = ENTRY_W'(MAX_ENTRIES);

    logic [1:0]         mode_reg, mode_next;
    logic               phase_reg, phase_next;
    logic [7:0]         pre_reg, pre_next;
    logic [7:0]         samp_reg, samp_next;
    logic [ENTRY_W-1:0] ent_reg, ent_next;
    logic [LIMIT_W-1:0] idle_reg, idle_next;

    logic [LIMIT_W-1:0] idle_inc;
    logic [ENTRY_W-1:0] ent_inc;
    logic [8:0]         cnt;
    logic [7:0]         pre_cur;
    logic [7:0]         dur;
    logic               meas;

    function automatic logic [7:0] reload(input logic [ENTRY_W-1:0] e, input cfg_t c);
        logic [7:0] p;
        p = (e < ENTRY_W'(2)) ? c.start_period : c.data_period;
        return (p != 8'd0) ? (p - 8'd1) : 8'd0;
    endfunction

    function automatic res_t final_res(input logic [ENTRY_W-1:0] e, input cfg_t c);
        res_t r;
        r.duration    = 8'd0;
        r.entry_index = '0;
        r.entry_total = e;
        r.status      = (e > c.min_entries) ? STATUS_ACCEPTED : STATUS_REJECTED;
        r.last        = 1'b1;
        return r;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        pre_next   = pre_reg;
        samp_next  = samp_reg;
        ent_next   = ent_reg;
        idle_next  = idle_reg;
        step       = '0;
        idle_inc   = idle_reg + LIMIT_W'(1);
        ent_inc    = ent_reg + ENTRY_W'(1);
        cnt        = {1'b0, samp_reg} + 9'd1;
        meas       = (mode_reg == MODE_MEASURE) || (mode_reg == MODE_WAIT && !sensor_level);
        pre_cur    = (mode_reg == MODE_WAIT) ? 8'd0 : pre_reg;
        dur        = samp_reg;
        if (dur == 8'd10 || dur == 8'd13 || dur == 8'd44)
        begin
            dur = dur + 8'd1;
        end

        if (accept)
        begin
            if (req_type)
            begin
                mode_next  = MODE_WAIT;
                phase_next = 1'b0;
                pre_next   = 8'd0;
                samp_next  = 8'd0;
                ent_next   = '0;
                idle_next  = '0;
            end
            else
            begin
                if (mode_reg == MODE_WAIT)
                begin
                    if (!sensor_level)
                    begin
                        mode_next = MODE_MEASURE;
                        pre_next  = 8'd0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                        if (idle_inc >= cfg.idle_limit)
                        begin
                            mode_next = MODE_MEASURE;
                            pre_next  = 8'd0;
                        end
                    end
                end

                if (meas)
                begin
                    if (pre_cur != 8'd0)
                    begin
                        pre_next = pre_cur - 8'd1;
                    end
                    else if (sensor_level == phase_reg)
                    begin
                        if (cnt > {1'b0, cfg.duration_limit})
                        begin
                            // Phase timed out: drop it and close the capture.
                            step.push0 = 1'b1;
                            step.res0  = final_res(ent_reg, cfg);
                            mode_next  = MODE_IDLE;
                            samp_next  = 8'd0;
                            pre_next   = 8'd0;
                        end
                        else
                        begin
                            samp_next = cnt[7:0];
                            pre_next  = reload(ent_reg, cfg);
                        end
                    end
                    else
                    begin
                        // Level change: emit the finished phase.
                        step.push0             = 1'b1;
                        step.res0.duration     = dur;
                        step.res0.entry_index  = ent_reg;
                        step.res0.entry_total  = '0;
                        step.res0.status       = STATUS_ENTRY;
                        step.res0.last         = 1'b0;
                        ent_next               = ent_inc;
                        phase_next             = ~phase_reg;
                        if (ent_inc >= MAX_E || cfg.duration_limit == 8'd0)
                        begin
                            step.push1 = 1'b1;
                            step.res1  = final_res(ent_inc, cfg);
                            mode_next  = MODE_IDLE;
                            samp_next  = 8'd0;
                            pre_next   = 8'd0;
                        end
                        else
                        begin
                            samp_next = 8'd1;
                            pre_next  = reload(ent_inc, cfg);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= 1'b0;
            pre_reg   <= 8'd0;
            samp_reg  <= 8'd0;
            ent_reg   <= '0;
            idle_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            pre_reg   <= pre_next;
            samp_reg  <= samp_next;
            ent_reg   <= ent_next;
            idle_reg  <= idle_next;
        end
    end

    // The entry count never passes the table size.
    a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ent_reg <= MAX_E)
        else $error("entry count beyond table size");

    // A second result only follows an entry, and it always closes the capture.
    a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
        step.push1 |-> (step.push0 && step.res1.last && !step.res0.last))
        else $error("bad result pair");

    // Closing a capture leaves the engine idle.
    a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((step.push0 && step.res0.last) || step.push1) |=> (mode_reg == MODE_IDLE))
        else $error("capture not closed");

endmodule

### hw/rtl/ir_pwc_out_fifo.sv
// Result queue between the capture engine and the output stream.
// Depends on ir_pwc_pkg; takes up to two results per cycle, gives one.
module ir_pwc_out_fifo
    import ir_pwc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    input  logic  pop,
    output res_t  head,
    output logic  nonempty,
    output logic  room2
);

    res_t                q_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_reg, wr_next;
    logic [OQ_PTR_W-1:0] rd_reg, rd_next;
    logic [OQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OQ_CNT_W-1:0] n_push;
    logic                do_pop;

    assign nonempty = (cnt_reg != '0);
    assign room2    = (cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign head     = q_reg[rd_reg];
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        n_push   = OQ_CNT_W'(step.push0) + OQ_CNT_W'(step.push1);
        wr_next  = wr_reg + n_push[OQ_PTR_W-1:0];
        rd_next  = rd_reg + OQ_PTR_W'(do_pop);
        cnt_next = cnt_reg + n_push - OQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (step.push0)
        begin
            q_reg[wr_reg] <= step.res0;
        end
        if (step.push1)
        begin
            q_reg[wr_reg + OQ_PTR_W'(1)] <= step.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_reg - rd_reg) == cnt_reg[OQ_PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

### hw/rtl/ir_pulse_width_capture_core.sv
// Top level of the IR pulse width capture block.
// Depends on ir_pwc_pkg, ir_pwc_engine and ir_pwc_out_fifo.
//
// Usage: each input item is either one base tick carrying a sensor sample
// (s_tuser = 0) or an arm request (s_tuser = 1) that starts a new capture.
// An armed capture waits while the sensor sits high, then counts samples of
// alternating low and high phases. Every finished phase leaves as an entry
// item on the master stream; the capture closes with one item that has
// m_tlast high and says accepted or rejected against min_entries.
// Results of an item reach the master stream through the result queue.
// Throughput: one item per cycle while s_tready is high; the engine
// updates its state in the cycle of acceptance and pushes its results
// into a four-deep result queue.
// Stalls: when m_tready is low the results wait in the queue, and s_tready
// falls once fewer than two queue slots are free, since one tick can end a
// capture with both its last entry and the closing result.
// Reset: the capture is idle, the queue empty and the registers hold their
// default values (start 38, data 34, limit 250, idle 1200000, min 10).
// Configuration writes take effect at the clock edge where cfg_we is high;
// indexes beyond the register list are ignored.
module ir_pulse_width_capture_core
    import ir_pwc_pkg::*;
#(
    parameter int MAX_ENTRIES = 74
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] sensor_level, [7:1] zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] duration, [14:8] entry_index,
                                   // [21:15] entry_total, [23:22] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t  cfg_reg;
    step_t step;
    res_t  head;
    logic  accept;
    logic  nonempty;
    logic  room2;

    // Configuration registers; each write takes the low bits it needs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_period   <= 8'd38;
            cfg_reg.data_period    <= 8'd34;
            cfg_reg.duration_limit <= 8'd250;
            cfg_reg.idle_limit     <= 24'd1200000;
            cfg_reg.min_entries    <= 7'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_PERIOD:   cfg_reg.start_period   <= cfg_data[7:0];
                REG_DATA_PERIOD:    cfg_reg.data_period    <= cfg_data[7:0];
                REG_DURATION_LIMIT: cfg_reg.duration_limit <= cfg_data[7:0];
                REG_IDLE_LIMIT:     cfg_reg.idle_limit     <= cfg_data[LIMIT_W-1:0];
                REG_MIN_ENTRIES:    cfg_reg.min_entries    <= cfg_data[ENTRY_W-1:0];
                default:            ;
            endcase
        end
    end

    // The queue must be able to absorb the worst case of two results.
    assign s_tready = room2;
    assign accept   = s_tvalid && s_tready;

    ir_pwc_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (s_tuser[0]),
        .sensor_level (s_tdata[0]),
        .cfg          (cfg_reg),
        .step         (step)
    );

    ir_pwc_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .pop      (m_tready),
        .head     (head),
        .nonempty (nonempty),
        .room2    (room2)
    );

    assign m_tvalid = nonempty;
    assign m_tdata  = {2'b00, head.entry_total, head.entry_index, head.duration};
    assign m_tuser  = head.status;
    assign m_tlast  = head.last;

    // The closing result and only it carries tlast, with a non-entry status.
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != STATUS_ENTRY)))
        else $error("tlast and status disagree");

endmodule

### verif/ir_pulse_width_capture_core_tb.sv
// Self-checking testbench for the IR pulse width capture core.
// It needs ir_pwc_pkg and the RTL of the core, its engine and its result queue.
// A built-in predictor models each tick, and every result item is checked.
module ir_pulse_width_capture_core_tb;
    import ir_pwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES  = 74;
    // Results are queued in the core when their item is taken, so a short
    // settle after the last result covers any tick that is still in flight.
    localparam int DRAIN_CYCLES = 8;
    // Watchdog limit, well above the slowest correct run even with every
    // sender gap and every receiver stall at their longest.
    localparam int CYCLE_LIMIT  = 600_000;
    // Random traffic tops the run up to roughly this many input items.
    localparam int ITEM_TARGET  = 1800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [0] sensor_level, [7:1] zero
    logic [0:0]  s_tuser = '0;    // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [7:0] duration, [14:8] entry_index,
                                  // [21:15] entry_total, [23:22] zero
    logic [1:0]  m_tuser;         // [1:0] status
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    ir_pulse_width_capture_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the registers, updated on every write.
    cfg_t cfg_shadow;

    // Predictor state of the capture engine.
    logic [1:0]  cap_mode;
    logic        phase_lvl;
    logic [7:0]  presc_cnt;
    logic [7:0]  sample_cnt;
    logic [6:0]  entries_done;
    logic [23:0] idle_wait_cnt;

    // Result items predicted but not yet seen on the master side, oldest first.
    res_t expected_results[$];

    // Knobs shared by the tests and the two stream processes.
    bit src_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    int sink_hold_cycles = 0;

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned entries_checked = 0;
    int unsigned captures_closed = 0;
    int unsigned settings_applied = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // The prescaler reloads with the period of the entry now being measured:
    // the start period for the first two entries, the data period after that.
    task automatic reload_prescaler();
        logic [7:0] per;
        per = (entries_done < 2) ? cfg_shadow.start_period : cfg_shadow.data_period;
        presc_cnt = (per != 0) ? per - 8'd1 : 8'd0;
    endtask

    // Closing item: carries the entry count and the accept or reject verdict.
    task automatic close_capture();
        res_t r;
        r.duration    = '0;
        r.entry_index = '0;
        r.entry_total = entries_done;
        r.status      = (entries_done > cfg_shadow.min_entries) ? STATUS_ACCEPTED
                                                                : STATUS_REJECTED;
        r.last        = 1'b1;
        expected_results.push_back(r);
        cap_mode   = MODE_IDLE;
        sample_cnt = '0;
        presc_cnt  = '0;
    endtask

    // Advances the predicted capture by one accepted item and queues the
    // result items that this item produces.
    task automatic predict_capture_tick(input bit req, input bit lvl);
        int   cnt;
        res_t r;
        if (req)
        begin
            // An arm drops whatever capture was running, silently.
            cap_mode      = MODE_WAIT;
            phase_lvl     = 1'b0;
            presc_cnt     = '0;
            sample_cnt    = '0;
            entries_done  = '0;
            idle_wait_cnt = '0;
            return;
        end
        if (cap_mode == MODE_WAIT)
        begin
            if (!lvl)
            begin
                // Falls through: this same tick is the first low sample.
                cap_mode  = MODE_MEASURE;
                presc_cnt = '0;
            end
            else
            begin
                idle_wait_cnt = idle_wait_cnt + 24'd1;
                if (idle_wait_cnt >= cfg_shadow.idle_limit)
                begin
                    cap_mode  = MODE_MEASURE;
                    presc_cnt = '0;
                end
                return;
            end
        end
        if (cap_mode != MODE_MEASURE)
            return;
        if (presc_cnt != 0)
        begin
            presc_cnt = presc_cnt - 8'd1;
            return;
        end
        cnt = sample_cnt;
        if (lvl == phase_lvl)
        begin
            cnt++;
            if (cnt > cfg_shadow.duration_limit)
            begin
                close_capture();
                return;
            end
            sample_cnt = 8'(cnt);
            reload_prescaler();
            return;
        end
        // Level change: emit the finished phase. Lengths of 10, 13 and 44 are
        // bumped by one on the way out.
        r.duration = sample_cnt;
        if (r.duration == 8'd10 || r.duration == 8'd13 || r.duration == 8'd44)
            r.duration = r.duration + 8'd1;
        r.entry_index = entries_done;
        r.entry_total = '0;
        r.status      = STATUS_ENTRY;
        r.last        = 1'b0;
        expected_results.push_back(r);
        entries_done = entries_done + 7'd1;
        phase_lvl    = ~phase_lvl;
        if (entries_done >= MAX_ENTRIES || cfg_shadow.duration_limit < 1)
            close_capture();
        else
        begin
            sample_cnt = 8'd1;
            reload_prescaler();
        end
    endtask

    // ------------------------------------------------------------------
    // Stream and register drivers
    // ------------------------------------------------------------------

    // Offers one item on the slave side after a random gap and returns at the
    // rising edge where it is taken, with tvalid still high.
    task automatic send_item(input bit req, input bit lvl);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 9) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {7'd0, lvl};
        do
            @(posedge clk);
        while (!s_tready);
        predict_capture_tick(req, lvl);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has been
    // checked, plus a short settle so the core is idle again.
    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_START_PERIOD:   cfg_shadow.start_period   = val[7:0];
            REG_DATA_PERIOD:    cfg_shadow.data_period    = val[7:0];
            REG_DURATION_LIMIT: cfg_shadow.duration_limit = val[7:0];
            REG_IDLE_LIMIT:     cfg_shadow.idle_limit     = val;
            REG_MIN_ENTRIES:    cfg_shadow.min_entries    = val[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] sp, input logic [7:0] dp,
                                input logic [7:0] lim, input logic [23:0] idl,
                                input logic [6:0] mn);
        wait_results_drained();
        write_reg(REG_START_PERIOD, {16'd0, sp});
        write_reg(REG_DATA_PERIOD, {16'd0, dp});
        write_reg(REG_DURATION_LIMIT, {16'd0, lim});
        write_reg(REG_IDLE_LIMIT, idl);
        write_reg(REG_MIN_ENTRIES, {17'd0, mn});
        settings_applied++;
    endtask

    // One well-formed capture: an arm, some idle-high ticks, then phases that
    // alternate low and high. Phase lengths are chosen in samples and turned
    // into ticks with the period in force, so most land on exact counts.
    // With marked set, lengths cluster around the bumped values.
    task automatic play_capture(input int n_phases, input int max_samples,
                                input int lead_high, input bit marked);
        int per;
        int samples;
        int marked_len[9];
        marked_len = '{9, 10, 11, 12, 13, 14, 43, 44, 45};
        send_item(1'b1, 1'($urandom_range(0, 1)));
        repeat (lead_high) send_item(1'b0, 1'b1);
        for (int i = 0; i < n_phases; i++)
        begin
            per     = (i < 2) ? cfg_shadow.start_period : cfg_shadow.data_period;
            samples = marked ? marked_len[$urandom_range(0, 8)]
                             : $urandom_range(1, max_samples);
            repeat (samples * per) send_item(1'b0, i[0]);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_result();
        res_t got;
        res_t want;
        got.duration    = m_tdata[7:0];
        got.entry_index = m_tdata[14:8];
        got.entry_total = m_tdata[21:15];
        got.status      = m_tuser;
        got.last        = m_tlast;
        if (got.last === 1'b1)
            captures_closed++;
        else
            entries_checked++;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            $error("result with nothing predicted: duration %0d index %0d total %0d",
                   got.duration, got.entry_index, got.entry_total);
            return;
        end
        want = expected_results.pop_front();
        if (got.duration !== want.duration)
        begin
            mismatches++;
            $error("duration: expected %0d, got %0d", want.duration, got.duration);
        end
        if (got.entry_index !== want.entry_index)
        begin
            mismatches++;
            $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
        end
        if (got.entry_total !== want.entry_total)
        begin
            mismatches++;
            $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
        end
        if (got.status !== want.status)
        begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, got.status);
        end
        if (got.last !== want.last)
        begin
            mismatches++;
            $error("last: expected %0b, got %0b", want.last, got.last);
        end
    endtask

    // Master-side receiver. It stalls a random number of cycles before each
    // item, or for one long stretch when a test asks for a hold-off; the
    // hold-off is counted here, in cycles, while the sender keeps going.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            else
                stall = sink_stalls_on ? $urandom_range(0, 9) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_tready = 1'b0;
            end
            @(negedge clk);
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            check_result();
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ir_pulse_width_capture_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked corners with periods of one, so each tick is a sample.
    task automatic test_directed_corners();
        // Ticks with nothing armed produce nothing.
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        apply_config(8'd1, 8'd1, 8'd3, 24'd2, 7'd2);
        // Arm with the sensor level set, which must be ignored.
        send_item(1'b1, 1'b1);
        // Two high ticks run out the idle wait; the next tick is the first
        // sample of the low phase but sees high, so entry 0 is zero long.
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        // Re-arm in the middle of a capture: dropped without a closing item.
        send_item(1'b1, 1'b0);
        // A low tick ends the wait and counts as the first low sample.
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        // The high phase overruns the limit of three: timeout, one entry,
        // which is not above the minimum of two, so rejected.
        repeat (3) send_item(1'b0, 1'b1);
        // Idle limit of zero ends the wait after a single high tick, and a
        // minimum of zero accepts a single-entry capture.
        apply_config(8'd1, 8'd1, 8'd3, 24'd0, 7'd0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        repeat (3) send_item(1'b0, 1'b1);
    endtask

    // Phases of 10, 13 and 44 samples and their neighbors.
    task automatic test_marked_durations();
        apply_config(8'd1, 8'd1, 8'd60, 24'd4, 7'd3);
        repeat (2) play_capture(6, 1, $urandom_range(0, 2), 1'b1);
        // Let the last phase run out so the capture closes on a timeout.
        repeat (62) send_item(1'b0, 1'b0);
    endtask

    // The wait for the sensor to leave idle, with small limits, some of
    // them expiring while the sensor is still high.
    task automatic test_idle_expiry();
        int lims[4];
        lims = '{0, 1, 3, 7};
        foreach (lims[k])
        begin
            apply_config(8'd1, 8'd2, 8'd6, 24'(lims[k]), 7'd2);
            repeat (4)
                play_capture($urandom_range(2, 8), 4, $urandom_range(0, lims[k] + 3), 1'b0);
        end
    endtask

    // Captures long enough to fill the table. With a minimum of 74 a full
    // table is still rejected; with 73 it is accepted. Ticks after the close
    // land on an idle core and are ignored.
    task automatic test_table_full();
        apply_config(8'd1, 8'd1, 8'd254, 24'hFFFFFF, 7'd74);
        play_capture(MAX_ENTRIES + 3, 3, $urandom_range(0, 3), 1'b0);
        apply_config(8'd1, 8'd1, 8'd254, 24'hFFFFFF, 7'd73);
        play_capture(MAX_ENTRIES + 3, 3, $urandom_range(0, 3), 1'b0);
    endtask

    // Longest sampling periods. Levels between samples are random and must
    // have no effect.
    task automatic test_period_extremes();
        // Longest start period: one full period between the first two
        // samples. The capture is left open and the next arm drops it.
        apply_config(8'd255, 8'd255, 8'd1, 24'd5, 7'd0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        repeat (254) send_item(1'b0, 1'($urandom_range(0, 1)));
        send_item(1'b0, 1'b1);
        // Short start period, longest data period from entry 2 on.
        apply_config(8'd1, 8'd255, 8'd1, 24'd5, 7'd0);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        repeat (254) send_item(1'b0, 1'($urandom_range(0, 1)));
        send_item(1'b0, 1'b0);
    endtask

    // The receiver holds off for a long stretch while dense captures keep
    // coming, so the result queue fills and the input stalls. Afterwards
    // the sender pauses until every result is through, then resumes.
    task automatic test_backpressure();
        apply_config(8'd1, 8'd1, 8'd8, 24'd2, 7'd1);
        src_gaps_on = 1'b0;
        sink_hold_cycles = 300;
        repeat (3) play_capture(12, 2, 1, 1'b0);
        wait_results_drained();
        src_gaps_on = 1'b1;
        repeat (2) play_capture(10, 3, 0, 1'b0);
    endtask

    // Bulk random traffic: rounds of random settings, each with mostly
    // well-formed captures and some noise with stray arms, until the run
    // has sent about ITEM_TARGET items.
    task automatic test_random_traffic();
        logic [7:0]  lim;
        logic [23:0] idl;
        do
        begin
            lim = 8'($urandom_range(1, 12));
            idl = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                              : 24'($urandom_range(0, 6));
            apply_config(8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)), lim, idl,
                         7'($urandom_range(0, 12)));
            // Some rounds run without gaps on one side or both.
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (3)
            begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(5, 20))
                        send_item(1'($urandom_range(0, 15) == 0), 1'($urandom_range(0, 1)));
                else
                    play_capture($urandom_range(1, 12), lim + 1, $urandom_range(0, 8), 1'b0);
            end
        end
        while (items_sent < ITEM_TARGET);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial
    begin
        cfg_shadow.start_period   = 8'd38;
        cfg_shadow.data_period    = 8'd34;
        cfg_shadow.duration_limit = 8'd250;
        cfg_shadow.idle_limit     = 24'd1200000;
        cfg_shadow.min_entries    = 7'd10;
        cap_mode      = MODE_IDLE;
        phase_lvl     = 1'b0;
        presc_cnt     = '0;
        sample_cnt    = '0;
        entries_done  = '0;
        idle_wait_cnt = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_marked_durations();
        test_idle_expiry();
        test_table_full();
        test_period_extremes();
        test_backpressure();
        test_random_traffic();

        wait_results_drained();
        $display("Sent %0d items over %0d register settings;", items_sent, settings_applied);
        $display("checked %0d entries and %0d closed captures.",
                 entries_checked, captures_closed);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ir_pulse_width_capture_core: match");
        else
            $display("ir_pulse_width_capture_core: mismatch");
        $finish;
    end

endmodule
